FILE: rtl/ifhb_pkg.sv
// ============================================================================
// ifhb_pkg
// Shared types and constants for the IPv4 fragment header builder.
// ============================================================================
package ifhb_pkg;

    // Fragment geometry
    localparam logic [15:0] FRAG_PAYLOAD = 16'd1480;
    localparam logic [10:0] HDR_BYTES    = 11'd20;
    localparam logic [12:0] OFFSET_STEP  = 13'd185;   // 1480 / 8

    // Fixed header words
    localparam logic [15:0] VER_IHL_TOS  = 16'h4500;  // version 4, IHL 5, TOS 0
    localparam logic [7:0]  TTL_VALUE    = 8'd64;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BASE,
        ST_LOAD,
        ST_SEND
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch request, assign packet id
        logic base_sum;  // register the per-request part of the checksum
        logic load;      // build one fragment into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last;      // fragment in the output register is the final one
    } t_sts;

endpackage

FILE: rtl/ipv4_fragment_header_builder.sv
// ============================================================================
// ipv4_fragment_header_builder
// Splits one send request into IPv4 fragments and emits one header result
// per fragment, with id, offset, flags and header checksum.
// ============================================================================
//
//  Channel   Direction  Handshake            Payload
//  request   in         i_valid / o_stall    payload_length, dest_address, protocol
//  fragment  out        o_valid / i_stall    total_length .. last
//  config    in         i_cfg_wr_en          i_cfg_wr_data (local address)
//
//  A request runs through capture, checksum base and first fragment build, then
//  one fragment per cycle from the sequencer's fragment loop while the output
//  is not stalled; a request gives 1 to 45 fragments. o_stall is high from the
//  capture until the last fragment is taken. A stall on the output holds the
//  fragment register and the sequencer. Synchronous active-low reset clears
//  the local address, the packet id counter and the sequencer.
//
module ipv4_fragment_header_builder
    import ifhb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_payload_length,
    input  logic [31:0] i_dest_address,
    input  logic [7:0]  i_protocol,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [10:0] o_total_length,
    output logic [15:0] o_packet_id,
    output logic [12:0] o_fragment_offset,
    output logic        o_more_fragments,
    output logic [15:0] o_header_checksum,
    output logic [15:0] o_payload_start,
    output logic        o_last
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    ifhb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath
    ifhb_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_payload_length  (i_payload_length),
        .i_dest_address    (i_dest_address),
        .i_protocol        (i_protocol),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_total_length    (o_total_length),
        .o_packet_id       (o_packet_id),
        .o_fragment_offset (o_fragment_offset),
        .o_more_fragments  (o_more_fragments),
        .o_header_checksum (o_header_checksum),
        .o_payload_start   (o_payload_start),
        .o_last            (o_last)
    );

`ifndef ASSERT_OFF
    // A taken fragment that is not the last is followed at once by the next
    a_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid)
        else $error("fragment stream broke before the last fragment");

    // The last flag and the more-fragments flag are complements
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == !o_more_fragments))
        else $error("last and more_fragments disagree");

    // Every fragment but the last is full size
    a_full_frag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_total_length == 11'd1500)
        else $error("non-final fragment is not full size");

    // A captured request keeps the input side busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall && !o_valid)
        else $error("request capture did not block the input");
`endif

endmodule

FILE: rtl/ifhb_ctrl.sv
// ============================================================================
// ifhb_ctrl
// Sequencer for the fragment header builder: takes a request, primes the
// checksum base, then issues one fragment per cycle as the sink allows.
// ============================================================================
module ifhb_ctrl
    import ifhb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // Hold state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance through request phases
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_BASE;
            end
            ST_BASE: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = ST_SEND;
            end
            ST_SEND: begin
                if (!i_stall && i_sts.last) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Drive handshakes and datapath commands
    always_comb begin
        o_stall  = 1'b1;
        o_valid  = 1'b0;
        o_cmd    = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
            end
            ST_BASE: begin
                o_cmd.base_sum = 1'b1;
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
            end
            ST_SEND: begin
                o_valid    = 1'b1;
                o_cmd.load = !i_stall && !i_sts.last;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/ifhb_dp.sv
// ============================================================================
// ifhb_dp
// Datapath for the fragment header builder: request registers, fragment
// counters, checksum adder and the result register.
// ============================================================================
module ifhb_dp
    import ifhb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic [15:0] i_payload_length,
    input  logic [31:0] i_dest_address,
    input  logic [7:0]  i_protocol,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [10:0] o_total_length,
    output logic [15:0] o_packet_id,
    output logic [12:0] o_fragment_offset,
    output logic        o_more_fragments,
    output logic [15:0] o_header_checksum,
    output logic [15:0] o_payload_start,
    output logic        o_last
);

    logic [31:0] r_local_addr;
    logic [15:0] r_next_id;
    logic [15:0] r_id;
    logic [31:0] r_dst;
    logic [7:0]  r_proto;
    logic [15:0] r_remaining;
    logic [15:0] r_start;
    logic [12:0] r_offset;
    logic [18:0] r_base;

    logic        frag_more;
    logic [10:0] frag_len;
    logic [10:0] frag_tot;
    logic [15:0] frag_flagoff;
    logic [18:0] n_base;
    logic [19:0] sum_all;
    logic [16:0] sum_fold1;
    logic [15:0] sum_fold2;

    // Hold source address and packet id counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr <= '0;
            r_next_id    <= '0;
        end else begin
            if (i_cfg_wr_en) r_local_addr <= i_cfg_wr_data;
            if (i_cmd.capture) r_next_id <= r_next_id + 16'd1;
        end
    end

    // Sum the header words that stay fixed over the request
    assign n_base = 19'(VER_IHL_TOS) + 19'(r_id) + 19'({TTL_VALUE, r_proto})
                  + 19'(r_local_addr[31:16]) + 19'(r_local_addr[15:0])
                  + 19'(r_dst[31:16]) + 19'(r_dst[15:0]);

    // Shape the current fragment
    assign frag_more    = r_remaining > FRAG_PAYLOAD;
    assign frag_len     = frag_more ? FRAG_PAYLOAD[10:0] : r_remaining[10:0];
    assign frag_tot     = frag_len + HDR_BYTES;
    assign frag_flagoff = {2'b00, frag_more, r_offset};

    // Finish the one's-complement checksum
    assign sum_all   = 20'(r_base) + 20'(frag_tot) + 20'(frag_flagoff);
    assign sum_fold1 = 17'(sum_all[15:0]) + 17'(sum_all[19:16]);
    assign sum_fold2 = sum_fold1[15:0] + 16'(sum_fold1[16]);

    // Latch request, step counters, load result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_id        <= r_next_id;
            r_dst       <= i_dest_address;
            r_proto     <= i_protocol;
            r_remaining <= i_payload_length;
            r_start     <= '0;
            r_offset    <= '0;
        end
        if (i_cmd.base_sum) begin
            r_base <= n_base;
        end
        if (i_cmd.load) begin
            o_total_length    <= frag_tot;
            o_packet_id       <= r_id;
            o_fragment_offset <= r_offset;
            o_more_fragments  <= frag_more;
            o_header_checksum <= ~sum_fold2;
            o_payload_start   <= r_start;
            o_last            <= !frag_more;
            r_remaining       <= r_remaining - FRAG_PAYLOAD;
            r_start           <= r_start + FRAG_PAYLOAD;
            r_offset          <= r_offset + OFFSET_STEP;
        end
    end

    assign o_sts.last = o_last;

endmodule
